// ===== rtl/core/ssc_pkg.sv =====
// shared types, codes and crc functions for the sensor frame builder and checker
package ssc_pkg;

  localparam int unsigned SSC_QUEUE_DEPTH = 4;

  localparam logic [7:0] CRC_POLY = 8'h1D;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [3:0] LOCK_CODE = 4'hA;
  localparam logic [5:0] LOCK_ADDR_LO = 6'h04;
  localparam logic [5:0] LOCK_ADDR_HI = 6'h12;
  localparam logic [3:0] WRITE_LEN = 4'd1;

  localparam int unsigned BIT_ANGLE_OK = 12;
  localparam int unsigned BIT_IFACE_OK = 13;
  localparam int unsigned BIT_SYSTEM_OK = 14;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_WORD = 1'b1;

  localparam logic [1:0] KIND_CMD = 2'd0;
  localparam logic [1:0] KIND_ECHO = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_ECHO = 3'd1;
  localparam logic [2:0] ST_ANGLE = 3'd2;
  localparam logic [2:0] ST_IFACE = 3'd3;
  localparam logic [2:0] ST_SYSTEM = 3'd4;
  localparam logic [2:0] ST_CRC = 3'd5;

  typedef enum logic [1:0] {
    OP_CMD,
    OP_ECHO,
    OP_DATA,
    OP_SAFETY
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] word;
    logic        fail;
  } entry_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] crc_word(input logic [7:0] crc, input logic [15:0] w);
    return crc_byte(crc_byte(crc, w[15:8]), w[7:0]);
  endfunction

endpackage

// ===== rtl/core/ssc_if.sv =====
// request and result channel interfaces
interface ssc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        is_write;
  logic [5:0]  address;
  logic [3:0]  count;
  logic        buffered;
  logic [15:0] rx_word;

  modport source (output valid, req_type, is_write, address, count, buffered, rx_word,
                  input ready);
  modport sink (input valid, req_type, is_write, address, count, buffered, rx_word,
                output ready);
endinterface

interface ssc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] word_value;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, kind, word_value, status, last, input ready);
  modport sink (input valid, kind, word_value, status, last, output ready);
endinterface

// ===== rtl/core/ssc_queue.sv =====
// small fifo of classified requests between front and back
module ssc_queue #(
  parameter int unsigned Depth = ssc_pkg::SSC_QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  ssc_pkg::entry_t              push_entry,
  input  logic                         pop,
  output ssc_pkg::entry_t              head,
  output logic                         head_valid,
  output logic                         full,
  output logic [$clog2(Depth+1)-1:0]   fill
);
  import ssc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  entry_t slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] cnt;

  assign head = slots[rd_ptr];
  assign head_valid = (cnt != '0);
  assign full = (cnt == CntFull);
  assign fill = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== rtl/core/ssc_front.sv =====
// front end: frame sequencing, command build and echo compare
module ssc_front (
  input  logic            clk,
  input  logic            rst,
  ssc_req_if.sink         req,
  input  logic            q_full,
  output logic            push,
  output ssc_pkg::entry_t push_entry
);
  import ssc_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ECHO,
    PH_DATA,
    PH_SAFETY
  } phase_t;

  phase_t      phase;
  phase_t      phase_next;
  logic [15:0] sent_command;
  logic [15:0] cmd;
  logic [4:0]  words_left;
  logic [4:0]  words_left_next;
  logic        echo_failed;
  logic        echo_failed_next;
  logic        fire;
  logic        lock;
  logic        mismatch;

  assign req.ready = !q_full;
  assign fire = req.valid && req.ready;
  assign lock = (req.address > LOCK_ADDR_LO) && (req.address < LOCK_ADDR_HI);
  assign mismatch = (req.rx_word != sent_command);

  always_comb begin
    cmd[15] = !req.is_write;
    cmd[14:11] = lock ? LOCK_CODE : 4'h0;
    cmd[10] = req.is_write ? 1'b0 : req.buffered;
    cmd[9:4] = req.address;
    cmd[3:0] = req.is_write ? WRITE_LEN : req.count;
  end

  always_comb begin
    phase_next = phase;
    words_left_next = words_left;
    echo_failed_next = echo_failed;
    push = 1'b0;
    push_entry.op = OP_CMD;
    push_entry.word = req.rx_word;
    push_entry.fail = 1'b0;
    if (req.req_type == REQ_START) begin
      phase_next = PH_ECHO;
      words_left_next = req.is_write ? 5'd1 : {1'b0, req.count};
      echo_failed_next = 1'b0;
      push = fire;
      push_entry.word = cmd;
    end else begin
      case (phase)
        PH_ECHO: begin
          echo_failed_next = mismatch;
          phase_next = (words_left != '0) ? PH_DATA : PH_SAFETY;
          push = fire;
          push_entry.op = OP_ECHO;
          push_entry.fail = mismatch;
        end
        PH_DATA: begin
          if (words_left != '0) begin
            words_left_next = words_left - 1'b1;
          end
          if (words_left_next == '0) begin
            phase_next = PH_SAFETY;
          end
          push = fire && !echo_failed;
          push_entry.op = OP_DATA;
        end
        PH_SAFETY: begin
          phase_next = PH_IDLE;
          push = fire;
          push_entry.op = OP_SAFETY;
          push_entry.fail = echo_failed;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      words_left <= '0;
      echo_failed <= 1'b0;
      sent_command <= '0;
    end else if (fire) begin
      phase <= phase_next;
      words_left <= words_left_next;
      echo_failed <= echo_failed_next;
      if (req.req_type == REQ_START) begin
        sent_command <= cmd;
      end
    end
  end

endmodule

// ===== rtl/core/ssc_back.sv =====
// back end: running crc, safety word check and result register
module ssc_back (
  input  logic            clk,
  input  logic            rst,
  input  ssc_pkg::entry_t head,
  input  logic            head_valid,
  output logic            pop,
  ssc_rsp_if.source       rsp
);
  import ssc_pkg::*;

  logic [7:0]  running_crc;
  logic [7:0]  crc_upd;
  logic [7:0]  expect_crc;
  logic [2:0]  safety_status;
  logic [1:0]  kind_next;
  logic [15:0] word_next;
  logic [2:0]  status_next;

  assign pop = head_valid && (!rsp.valid || rsp.ready);
  assign crc_upd = crc_word(running_crc, head.word);
  assign expect_crc = ~running_crc;

  always_comb begin
    if (head.fail) begin
      safety_status = ST_ECHO;
    end else if (head.word[7:0] != expect_crc) begin
      safety_status = ST_CRC;
    end else if (!head.word[BIT_ANGLE_OK]) begin
      safety_status = ST_ANGLE;
    end else if (!head.word[BIT_IFACE_OK]) begin
      safety_status = ST_IFACE;
    end else if (!head.word[BIT_SYSTEM_OK]) begin
      safety_status = ST_SYSTEM;
    end else begin
      safety_status = ST_OK;
    end
  end

  always_comb begin
    kind_next = KIND_CMD;
    word_next = head.word;
    status_next = ST_OK;
    case (head.op)
      OP_CMD: begin
        kind_next = KIND_CMD;
      end
      OP_ECHO: begin
        kind_next = KIND_ECHO;
        status_next = head.fail ? ST_ECHO : ST_OK;
      end
      OP_DATA: begin
        kind_next = KIND_DATA;
      end
      OP_SAFETY: begin
        kind_next = KIND_STATUS;
        word_next = '0;
        status_next = safety_status;
      end
      default: begin
        kind_next = KIND_CMD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
      running_crc <= CRC_INIT;
    end else begin
      if (pop) begin
        rsp.valid <= 1'b1;
        case (head.op)
          OP_CMD: running_crc <= CRC_INIT;
          OP_ECHO: begin
            if (!head.fail) begin
              running_crc <= crc_upd;
            end
          end
          OP_DATA: running_crc <= crc_upd;
          default: running_crc <= running_crc;
        endcase
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp.kind <= kind_next;
      rsp.word_value <= word_next;
      rsp.status <= status_next;
      rsp.last <= (head.op == OP_SAFETY);
    end
  end

endmodule

// ===== rtl/core/ssc_frame_builder_and_checker.sv =====
// top level of the sensor spi frame builder and checker
// an accepted request is queued and loads the result register when the back end pops it
// throughput: one request per cycle while the queue is not full, set by the front sequencer
// and the one-word crc update; the queue lets requests flow on while results are stalled,
// until it holds QueueDepth entries
// synchronous reset returns the frame to idle, empties the queue and seeds the crc with 0xff
module ssc_frame_builder_and_checker #(
  parameter int unsigned QueueDepth = ssc_pkg::SSC_QUEUE_DEPTH
) (
  input logic       clk,
  input logic       rst,
  ssc_req_if.sink   item,
  ssc_rsp_if.source result
);
  import ssc_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic            push;
  logic            pop;
  logic            q_full;
  logic            head_valid;
  entry_t          push_entry;
  entry_t          head;
  logic [CntW-1:0] q_fill;

  ssc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (item),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  ssc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full),
    .fill       (q_fill)
  );

  ssc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .rsp        (result)
  );

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push |=> (q_fill != '0))
    else $error("queued request lost");

  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.last) |-> (result.kind == KIND_STATUS))
    else $error("last flag on a non-status result");

  a_cmd_clean: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.kind == KIND_CMD || result.kind == KIND_DATA))
      |-> (result.status == ST_OK && !result.last))
    else $error("command or data result carries status");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (q_fill != '0))
    else $error("pop from empty queue");

endmodule
